### rtl/ptt_pkg.sv
// Package: widths, request and status codes, and sizes for the periodic timer table.
`default_nettype none

package ptt_pkg;

   localparam int DATA_W          = 32;
   localparam int REQ_W           = 2;
   localparam int STATUS_W        = 3;
   localparam int MAX_TIMERS_DEF  = 16;
   localparam int RESULT_LIMIT    = 16;
   localparam int FIRE_CNT_W      = $clog2(RESULT_LIMIT + 1);

   localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] STS_ADDED     = 3'd0;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STS_DELETED   = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STS_FIRED     = 3'd4;

endpackage

`default_nettype wire

### rtl/ptt_if.sv
// Interfaces: request and response channels of the periodic timer table.
`default_nettype none

interface ptt_req_if
   import ptt_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [DATA_W-1:0] start_delay;
   logic [DATA_W-1:0] period;
   logic [DATA_W-1:0] target_handle;

   modport source (output valid, output req_type, output start_delay, output period,
                   output target_handle, input ready);
   modport sink (input valid, input req_type, input start_delay, input period,
                 input target_handle, output ready);
endinterface

interface ptt_rsp_if
   import ptt_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   result_handle;
   logic                last_of_run;

   modport source (output valid, output status, output result_handle, output last_of_run,
                   input ready);
   modport sink (input valid, input status, input result_handle, input last_of_run,
                 output ready);
endinterface

`default_nettype wire

### rtl/periodic_timer_table.sv
// Top level: table of delayed periodic timers scanned one slot per cycle, held while a beat waits.
// Requests: one request per scan; a new request is taken only in the idle state, after the
// scan of the previous one has ended. The scan walks the slot memory at one slot per cycle,
// and holds while the response side holds back a beat.
// Reset (synchronous): empty table, tick counter 0, next handle 1, no response pending.
`default_nettype none

module periodic_timer_table
   import ptt_pkg::*;
#(
   parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   ptt_req_if.sink   req_ch,
   ptt_rsp_if.source rsp_ch
);

   localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int CNT_W = $clog2(MAX_TIMERS + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_type;

   state_type               state_ff, state_in;
   logic [REQ_W-1:0]        op_ff, op_in;
   logic [DATA_W-1:0]       delay_ff, delay_in;
   logic [DATA_W-1:0]       period_ff, period_in;
   logic [DATA_W-1:0]       target_ff, target_in;
   logic [DATA_W-1:0]       now_ff, now_in;
   logic [DATA_W-1:0]       next_handle_ff, next_handle_in;
   logic [MAX_TIMERS-1:0]   valid_ff, valid_in;
   logic [MAX_TIMERS-1:0]   started_ff, started_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic                    eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]        eval_idx_ff, eval_idx_in;
   logic [FIRE_CNT_W-1:0]   fire_cnt_ff, fire_cnt_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic [DATA_W-1:0]       pend_handle_ff, pend_handle_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]       rsp_handle_ff, rsp_handle_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [DATA_W-1:0] mem_handle  [MAX_TIMERS];
   logic [DATA_W-1:0] mem_created [MAX_TIMERS];
   logic [DATA_W-1:0] mem_delay   [MAX_TIMERS];
   logic [DATA_W-1:0] mem_period  [MAX_TIMERS];
   logic [DATA_W-1:0] mem_last    [MAX_TIMERS];

   logic [DATA_W-1:0] rd_handle_ff, rd_created_ff, rd_delay_ff, rd_period_ff, rd_last_ff;

   logic              rd_en;
   logic              add_we;
   logic              fire_we;
   logic              req_accept;
   logic              out_free;
   logic              eval_valid;
   logic              eval_started;
   logic [DATA_W-1:0] base_time;
   logic [DATA_W-1:0] threshold;
   logic [DATA_W-1:0] elapsed;
   logic [DATA_W-1:0] handle_inc;
   logic              hit;
   logic              scan_done;
   logic              stall;

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign req_accept          = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.result_handle = rsp_handle_ff;
   assign rsp_ch.last_of_run  = rsp_last_ff;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign eval_valid   = valid_ff[eval_idx_ff];
   assign eval_started = started_ff[eval_idx_ff];
   assign base_time    = eval_started ? rd_last_ff : rd_created_ff;
   assign threshold    = eval_started ? rd_period_ff : rd_delay_ff;
   assign elapsed      = now_ff - base_time;
   assign handle_inc   = next_handle_ff + DATA_W'(1);
   assign scan_done    = !eval_vld_ff && (idx_ff == CNT_W'(MAX_TIMERS));

   always_comb begin
      case (op_ff)
         REQ_ADD:    hit = eval_vld_ff && !eval_valid;
         REQ_DELETE: hit = eval_vld_ff && eval_valid && (rd_handle_ff == target_ff);
         REQ_TICK:   hit = eval_vld_ff && eval_valid && (elapsed > threshold);
         default:    hit = 1'b0;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      delay_in       = delay_ff;
      period_in      = period_ff;
      target_in      = target_ff;
      now_in         = now_ff;
      next_handle_in = next_handle_ff;
      valid_in       = valid_ff;
      started_in     = started_ff;
      idx_in         = idx_ff;
      eval_vld_in    = eval_vld_ff;
      eval_idx_in    = eval_idx_ff;
      fire_cnt_in    = fire_cnt_ff;
      pend_vld_in    = pend_vld_ff;
      pend_handle_in = pend_handle_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_last_in    = rsp_last_ff;
      rd_en          = 1'b0;
      add_we         = 1'b0;
      fire_we        = 1'b0;
      stall          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in       = req_ch.req_type;
               delay_in    = req_ch.start_delay;
               period_in   = req_ch.period;
               target_in   = req_ch.target_handle;
               idx_in      = '0;
               eval_vld_in = 1'b0;
               fire_cnt_in = '0;
               pend_vld_in = 1'b0;
               if (req_ch.req_type == REQ_TICK) begin
                  now_in = now_ff + DATA_W'(1);
               end
               state_in = (req_ch.req_type == REQ_UNUSED) ? S_FLUSH : S_SCAN;
            end
         end

         S_SCAN: begin
            if (hit) begin
               if (op_ff == REQ_TICK) begin
                  if (pend_vld_ff && !out_free) begin
                     stall = 1'b1;
                  end else begin
                     if (pend_vld_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_FIRED;
                        rsp_handle_in = pend_handle_ff;
                        rsp_last_in   = 1'b0;
                     end
                     pend_vld_in             = 1'b1;
                     pend_handle_in          = rd_handle_ff;
                     started_in[eval_idx_ff] = 1'b1;
                     fire_we                 = 1'b1;
                     fire_cnt_in             = fire_cnt_ff + FIRE_CNT_W'(1);
                     if (fire_cnt_ff == FIRE_CNT_W'(RESULT_LIMIT - 1)) begin
                        state_in = S_FLUSH;
                     end
                  end
               end else if (!out_free) begin
                  stall = 1'b1;
               end else begin
                  rsp_valid_in            = 1'b1;
                  rsp_last_in             = 1'b1;
                  started_in[eval_idx_ff] = 1'b0;
                  state_in                = S_IDLE;
                  if (op_ff == REQ_ADD) begin
                     rsp_status_in         = STS_ADDED;
                     rsp_handle_in         = next_handle_ff;
                     valid_in[eval_idx_ff] = 1'b1;
                     add_we                = 1'b1;
                     next_handle_in = (handle_inc == '0) ? DATA_W'(1) : handle_inc;
                  end else begin
                     rsp_status_in         = STS_DELETED;
                     rsp_handle_in         = target_ff;
                     valid_in[eval_idx_ff] = 1'b0;
                  end
               end
            end else if (scan_done) begin
               if (op_ff == REQ_TICK) begin
                  state_in = S_FLUSH;
               end else if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (op_ff == REQ_ADD) ? STS_FULL : STS_NOT_FOUND;
                  rsp_handle_in = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end

            // advance the read pipeline one slot
            if (!stall && state_in == S_SCAN) begin
               if (idx_ff != CNT_W'(MAX_TIMERS)) begin
                  rd_en       = 1'b1;
                  eval_vld_in = 1'b1;
                  eval_idx_in = idx_ff[IDX_W-1:0];
                  idx_in      = idx_ff + CNT_W'(1);
               end else begin
                  eval_vld_in = 1'b0;
               end
            end
         end

         S_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_FIRED;
               rsp_handle_in = pend_handle_ff;
               rsp_last_in   = 1'b1;
               pend_vld_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         now_ff         <= '0;
         next_handle_ff <= DATA_W'(1);
         valid_ff       <= '0;
         started_ff     <= '0;
         idx_ff         <= '0;
         eval_vld_ff    <= 1'b0;
         fire_cnt_ff    <= '0;
         pend_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         now_ff         <= now_in;
         next_handle_ff <= next_handle_in;
         valid_ff       <= valid_in;
         started_ff     <= started_in;
         idx_ff         <= idx_in;
         eval_vld_ff    <= eval_vld_in;
         fire_cnt_ff    <= fire_cnt_in;
         pend_vld_ff    <= pend_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff          <= op_in;
      delay_ff       <= delay_in;
      period_ff      <= period_in;
      target_ff      <= target_in;
      eval_idx_ff    <= eval_idx_in;
      pend_handle_ff <= pend_handle_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (add_we) begin
         mem_handle[eval_idx_ff]  <= next_handle_ff;
         mem_created[eval_idx_ff] <= now_ff;
         mem_delay[eval_idx_ff]   <= delay_ff;
         mem_period[eval_idx_ff]  <= period_ff;
      end
      if (fire_we) begin
         mem_last[eval_idx_ff] <= now_ff;
      end
      if (rd_en) begin
         rd_handle_ff  <= mem_handle[idx_ff[IDX_W-1:0]];
         rd_created_ff <= mem_created[idx_ff[IDX_W-1:0]];
         rd_delay_ff   <= mem_delay[idx_ff[IDX_W-1:0]];
         rd_period_ff  <= mem_period[idx_ff[IDX_W-1:0]];
         rd_last_ff    <= mem_last[idx_ff[IDX_W-1:0]];
      end
   end

endmodule

`default_nettype wire

### rtl/ptt_checker.sv
// Checker: port-level properties of the periodic timer table, bound to the top level.
`default_nettype none

module ptt_checker
   import ptt_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [DATA_W-1:0]   rsp_handle,
   input wire logic                rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_handle)
                                  && $stable(rsp_last))
      else $error("response beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous request still in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STS_FIRED)
      else $error("response status out of range");

   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == STS_FULL || rsp_status == STS_NOT_FOUND)
                     == (rsp_handle == '0)))
      else $error("response handle does not match status");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_FIRED |-> rsp_last)
      else $error("single-beat response without last flag");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_handle (rsp_ch.result_handle),
   .rsp_last   (rsp_ch.last_of_run)
);

`default_nettype wire

### test/tb_periodic_timer_table.sv
// Testbench: periodic timer table against an in-bench timer model, bursty requests, stalled beats.
`default_nettype none

module tb_periodic_timer_table;
   import ptt_pkg::*;

   localparam int SLOTS       = MAX_TIMERS_DEF;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_REQS = 130;
   localparam int DIR_COUNT   = 26;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   handle;
      logic                last;
   } timer_event_type;

   typedef struct packed {
      logic [REQ_W-1:0]    kind;
      logic [DATA_W-1:0]   dly;
      logic [DATA_W-1:0]   per;
      logic [DATA_W-1:0]   tgt;
      logic                fixed;
      logic [STATUS_W-1:0] fx_status;
      logic [DATA_W-1:0]   fx_handle;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      '{REQ_DELETE, 32'd0, 32'd0, 32'd0, 1'b1, STS_NOT_FOUND, 32'd0},
      '{REQ_TICK, 32'd0, 32'd0, 32'd0, 1'b0, STS_ADDED, 32'd0},
      '{REQ_ADD, 32'd0, 32'd0, 32'd0, 1'b1, STS_ADDED, 32'd1},
      '{REQ_TICK, 32'd0, 32'd0, 32'd0, 1'b0, STS_ADDED, 32'd0},
      '{REQ_TICK, 32'd0, 32'd0, 32'd0, 1'b0, STS_ADDED, 32'd0},
      '{REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1, STS_ADDED, 32'd2},
      '{REQ_ADD, 32'd2, 32'd3, 32'd0, 1'b1, STS_ADDED, 32'd3},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd4},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd5},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd6},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd7},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd8},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd9},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd10},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd11},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd12},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd13},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd14},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd15},
      '{REQ_ADD, 32'd0, 32'd1, 32'd0, 1'b1, STS_ADDED, 32'd16},
      '{REQ_ADD, 32'd5, 32'd5, 32'd0, 1'b1, STS_FULL, 32'd0},
      '{REQ_DELETE, 32'd0, 32'd0, 32'd2, 1'b1, STS_DELETED, 32'd2},
      '{REQ_DELETE, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, STS_NOT_FOUND, 32'd0},
      '{REQ_ADD, 32'd0, 32'd0, 32'd0, 1'b1, STS_ADDED, 32'd17},
      '{REQ_TICK, 32'd0, 32'd0, 32'd0, 1'b0, STS_ADDED, 32'd0},
      '{REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, STS_ADDED, 32'd0}
   };

   logic clock = 1'b0;
   logic reset;

   ptt_req_if req_ch ();
   ptt_rsp_if rsp_ch ();

   periodic_timer_table #(.MAX_TIMERS(SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   // typed expectation that travels with the request currently on the bus
   logic                drv_fixed;
   logic [STATUS_W-1:0] drv_fx_status;
   logic [DATA_W-1:0]   drv_fx_handle;

   // timer model state
   logic [DATA_W-1:0] now_ms;
   logic [DATA_W-1:0] next_id;
   logic              live     [SLOTS];
   logic              started  [SLOTS];
   logic [DATA_W-1:0] id       [SLOTS];
   logic [DATA_W-1:0] born     [SLOTS];
   logic [DATA_W-1:0] wait_ms  [SLOTS];
   logic [DATA_W-1:0] every_ms [SLOTS];
   logic [DATA_W-1:0] last_ms  [SLOTS];

   // copy of the table as it stood before the current edge, for picking delete targets
   logic              live_view [SLOTS];
   logic [DATA_W-1:0] id_view   [SLOTS];

   timer_event_type timer_events_q [$];

   int error_count = 0;
   int n_add = 0, n_full = 0, n_del = 0, n_miss = 0, n_tick = 0, n_fire = 0;
   int cycle_count = 0;
   int burst_left  = 0;

   always @(posedge clock) begin : timer_model
      timer_event_type   got, want;
      logic [DATA_W-1:0] span;
      logic              fire;
      int                s, hit, n;
      if (reset) begin
         now_ms  = '0;
         next_id = 32'd1;
         for (s = 0; s < SLOTS; s++) begin
            live[s]     = 1'b0;
            started[s]  = 1'b0;
            id[s]       = '0;
            born[s]     = '0;
            wait_ms[s]  = '0;
            every_ms[s] = '0;
            last_ms[s]  = '0;
         end
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.req_type)
               REQ_ADD: begin
                  hit = -1;
                  for (s = SLOTS - 1; s >= 0; s--)
                     if (!live[s]) hit = s;
                  if (hit < 0) begin
                     timer_events_q.push_back('{STS_FULL, 32'd0, 1'b1});
                     n_full++;
                  end else begin
                     live[hit]     = 1'b1;
                     started[hit]  = 1'b0;
                     id[hit]       = next_id;
                     born[hit]     = now_ms;
                     wait_ms[hit]  = req_ch.start_delay;
                     every_ms[hit] = req_ch.period;
                     last_ms[hit]  = '0;
                     timer_events_q.push_back('{STS_ADDED, next_id, 1'b1});
                     next_id = next_id + 32'd1;
                     if (next_id == '0) next_id = 32'd1;
                     n_add++;
                  end
               end
               REQ_DELETE: begin
                  hit = -1;
                  for (s = SLOTS - 1; s >= 0; s--)
                     if (live[s] && id[s] == req_ch.target_handle) hit = s;
                  if (hit < 0) begin
                     timer_events_q.push_back('{STS_NOT_FOUND, 32'd0, 1'b1});
                     n_miss++;
                  end else begin
                     live[hit]    = 1'b0;
                     started[hit] = 1'b0;
                     timer_events_q.push_back('{STS_DELETED, req_ch.target_handle, 1'b1});
                     n_del++;
                  end
               end
               REQ_TICK: begin
                  now_ms = now_ms + 32'd1;
                  n = 0;
                  for (s = 0; s < SLOTS && n < RESULT_LIMIT; s++) begin
                     fire = 1'b0;
                     if (live[s]) begin
                        if (!started[s]) begin
                           span = now_ms - born[s];
                           if (span > wait_ms[s]) begin
                              started[s] = 1'b1;
                              fire = 1'b1;
                           end
                        end else begin
                           span = now_ms - last_ms[s];
                           if (span > every_ms[s]) fire = 1'b1;
                        end
                     end
                     if (fire) begin
                        last_ms[s] = now_ms;
                        timer_events_q.push_back('{STS_FIRED, id[s], 1'b0});
                        n++;
                     end
                  end
                  if (n > 0) begin
                     want = timer_events_q.pop_back();
                     want.last = 1'b1;
                     timer_events_q.push_back(want);
                  end
                  n_tick++;
                  n_fire += n;
               end
               default: ;
            endcase
            if (drv_fixed) begin
               void'(timer_events_q.pop_back());
               timer_events_q.push_back('{drv_fx_status, drv_fx_handle, 1'b1});
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.status, rsp_ch.result_handle, rsp_ch.last_of_run};
            if (timer_events_q.size() == 0) begin
               $error("unexpected beat: status %0d, result_handle %0h", got.status, got.handle);
               error_count++;
            end else begin
               want = timer_events_q.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
               if (got.handle !== want.handle) begin
                  $error("result_handle: expected %0h, got %0h", want.handle, got.handle);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("last_of_run: expected %0d, got %0d", want.last, got.last);
                  error_count++;
               end
            end
         end
      end
      live_view <= live;
      id_view   <= id;
   end

   // response stalls: always ready, random, or a rotating mask; mode and mask are picked anew when a countdown runs out
   int       rx_left = 0;
   int       rx_mode = 0;
   logic [7:0] rx_mask = 8'hFF;

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= $urandom_range(0, 2);
         rx_mask <= 8'($urandom);
         rx_left <= $urandom_range(20, 80);
      end else begin
         rx_mask <= {rx_mask[6:0], rx_mask[7]};
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ch.ready <= rx_mask[0];
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic drive_request(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] dly,
                                input logic [DATA_W-1:0] per, input logic [DATA_W-1:0] tgt,
                                input logic fixed, input logic [STATUS_W-1:0] fx_status,
                                input logic [DATA_W-1:0] fx_handle);
      req_ch.req_type      <= kind;
      req_ch.start_delay   <= dly;
      req_ch.period        <= per;
      req_ch.target_handle <= tgt;
      req_ch.valid         <= 1'b1;
      drv_fixed            <= fixed;
      drv_fx_status        <= fx_status;
      drv_fx_handle        <= fx_handle;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic [DATA_W-1:0] pick_span();
      case ($urandom_range(0, 9))
         6:       return $urandom;
         7:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
         8:       return $urandom_range(7, 40);
         9:       return 32'd0;
         default: return $urandom_range(0, 6);
      endcase
   endfunction

   initial begin
      int               i, sent, roll, s;
      logic [REQ_W-1:0] kind;
      logic [DATA_W-1:0] tgt;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.req_type      <= REQ_ADD;
      req_ch.start_delay   <= '0;
      req_ch.period        <= '0;
      req_ch.target_handle <= '0;
      drv_fixed            <= 1'b0;
      drv_fx_status        <= STS_ADDED;
      drv_fx_handle        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 8);

      for (i = 0; i < DIR_COUNT; i++)
         drive_request(DIR_ROWS[i].kind, DIR_ROWS[i].dly, DIR_ROWS[i].per, DIR_ROWS[i].tgt,
                       DIR_ROWS[i].fixed, DIR_ROWS[i].fx_status, DIR_ROWS[i].fx_handle);

      sent = 0;
      while (sent < RANDOM_REQS) begin
         roll = $urandom_range(0, 99);
         kind = (roll < 35) ? REQ_ADD : (roll < 55) ? REQ_DELETE :
                (roll < 96) ? REQ_TICK : REQ_UNUSED;
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            s = $urandom_range(0, SLOTS - 1);
            tgt = live_view[s] ? id_view[s] : 32'($urandom_range(0, 40));
         end else if (roll < 80) begin
            tgt = $urandom_range(0, 40);
         end else begin
            tgt = $urandom;
         end
         drive_request(kind, pick_span(), pick_span(), tgt, 1'b0, STS_ADDED, 32'd0);
         if (kind != REQ_UNUSED) sent++;
      end
      req_ch.valid <= 1'b0;

      while (timer_events_q.size() != 0) @(posedge clock);
      repeat (4 * SLOTS) @(posedge clock);

      $display("run covered %0d adds, %0d refused on a full table, %0d deletes, %0d misses",
               n_add, n_full, n_del, n_miss);
      $display("and %0d ticks that fired %0d timers", n_tick, n_fire);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
rtl/ptt_pkg.sv
rtl/ptt_if.sv
rtl/periodic_timer_table.sv
rtl/ptt_checker.sv
test/tb_periodic_timer_table.sv
